// ----- src/ddc_pkg.sv -----
package ddc_pkg;

	localparam int TAPS = 401;
	localparam int CUTOFF_HZ = 4000;
	localparam int DEVICE_RATE_HZ = 240000;
	localparam int PHASE_BITS = 32;
	localparam int COEF_BITS = 18;
	localparam int SAMPLE_BITS = 16;

	localparam int ADDR_BITS = $clog2(TAPS);
	localparam int CW = 34;
	localparam int ITERS = 30;
	localparam int ITER_BITS = $clog2(ITERS);
	localparam int ACC_BITS = 44;
	localparam int MIX_BITS = SAMPLE_BITS + CW + 1;

	localparam logic [31:0] PHASE_STEP_RESET = 32'd143165577;
	localparam logic [7:0] DECIMATION_RESET = 8'd20;
	localparam longint CORDIC_GAIN_INV = 64'sd652032874;
	localparam longint TWO_PI_Q32 = 64'sd26986075409;
	localparam longint SINC_CENTRE = (TWO_PI_Q32 * CUTOFF_HZ) / DEVICE_RATE_HZ;
	localparam longint WIN_C0 = 376177;
	localparam longint WIN_C1 = 512009;
	localparam longint WIN_C2 = 148143;
	localparam longint WIN_C3 = 12247;

	typedef enum logic [0:0] {
		REG_PHASE_STEP = 1'b0,
		REG_DECIMATION = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CORDIC,
		S_MIX_I,
		S_MIX_Q,
		S_WRITE,
		S_FIR_START,
		S_FIR,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic cordic;
		logic mix_i;
		logic mix_q;
		logic write;
		logic fir_start;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic cordic_last;
		logic fire;
		logic fir_busy;
		logic out_full;
	} status_t;

	typedef logic signed [CW-1:0] atan_rom_t [ITERS];
	typedef logic signed [COEF_BITS-1:0] tap_rom_t [TAPS];
	typedef logic signed [SAMPLE_BITS-1:0] smp_rom_t [256];
	typedef struct packed {
		longint c;
		longint s;
	} sc_t;

	localparam longint ATAN_TAB [ITERS] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
		64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
		64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
		64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001
	};

	function automatic atan_rom_t build_atan();
		atan_rom_t t;
		for (int i = 0; i < ITERS; i++) begin
			t[i] = CW'(ATAN_TAB[i]);
		end
		return t;
	endfunction

	localparam atan_rom_t ATAN_ROM = build_atan();

	// long division of non-negative operands, for table building only
	function automatic longint udiv(longint n, longint d);
		longint q;
		longint r;
		q = 0;
		r = 0;
		for (int i = 62; i >= 0; i--) begin
			r = (r <<< 1) | ((n >>> i) & 64'sd1);
			if (r >= d) begin
				r = r - d;
				q = q | (longint'(1) <<< i);
			end
		end
		return q;
	endfunction

	// quotient truncated toward zero
	function automatic longint sdiv(longint n, longint d);
		longint q;
		q = udiv((n < 0) ? -n : n, (d < 0) ? -d : d);
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function automatic longint clamp_bits(longint v, int bits);
		longint hi;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	function automatic longint div_round(longint n, longint d);
		longint an;
		longint ad;
		longint q;
		an = (n < 0) ? -n : n;
		ad = (d < 0) ? -d : d;
		q = udiv(2 * an + ad, 2 * ad);
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function automatic sc_t sincos_q30(logic [31:0] phase);
		sc_t r;
		logic flip;
		logic [31:0] p;
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
		p = flip ? (phase ^ 32'h80000000) : phase;
		z = p[31] ? (longint'(p) - 64'sd4294967296) : longint'(p);
		x = CORDIC_GAIN_INV;
		y = 0;
		for (int i = 0; i < ITERS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_TAB[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_TAB[i];
			end
		end
		r.c = flip ? -x : x;
		r.s = flip ? -y : y;
		return r;
	endfunction

	function automatic tap_rom_t build_taps();
		tap_rom_t t;
		longint raw [TAPS];
		longint sum;
		longint d;
		longint ad;
		longint r;
		longint acc;
		longint w;
		longint pl;
		sc_t sc;
		sc_t s1;
		sc_t s2;
		sc_t s3;
		sum = 0;
		for (int i = 0; i < TAPS; i++) begin
			d = 2 * longint'(i) - (TAPS - 1);
			ad = (d < 0) ? -d : d;
			if (d == 0) begin
				r = SINC_CENTRE;
			end else begin
				pl = udiv((longint'(CUTOFF_HZ) * ad) <<< 31, longint'(DEVICE_RATE_HZ));
				sc = sincos_q30(pl[31:0]);
				r = sdiv(sc.s * 8, ad);
			end
			pl = udiv(longint'(i) <<< 32, longint'(TAPS - 1));
			s1 = sincos_q30(pl[31:0]);
			pl = udiv(longint'(2 * i) <<< 32, longint'(TAPS - 1));
			s2 = sincos_q30(pl[31:0]);
			pl = udiv(longint'(3 * i) <<< 32, longint'(TAPS - 1));
			s3 = sincos_q30(pl[31:0]);
			acc = WIN_C0 * 64'sd1073741824 - WIN_C1 * s1.c + WIN_C2 * s2.c - WIN_C3 * s3.c;
			w = acc >>> 30;
			raw[i] = (r * w) >>> 20;
			sum = sum + raw[i];
		end
		for (int i = 0; i < TAPS; i++) begin
			if (sum == 0) begin
				t[i] = '0;
			end else begin
				t[i] = COEF_BITS'(clamp_bits(
					div_round(raw[i] * (longint'(1) <<< (COEF_BITS - 1)), sum), COEF_BITS));
			end
		end
		return t;
	endfunction

	function automatic smp_rom_t build_samples();
		smp_rom_t t;
		longint n;
		for (int b = 0; b < 256; b++) begin
			n = (2 * longint'(b) - 255) * (longint'(1) <<< (SAMPLE_BITS - 1));
			t[b] = SAMPLE_BITS'(clamp_bits(div_round(n, 255), SAMPLE_BITS));
		end
		return t;
	endfunction

	localparam tap_rom_t TAP_ROM = build_taps();
	localparam smp_rom_t SAMPLE_ROM = build_samples();

endpackage

// ----- src/ddc_in_if.sv -----
interface ddc_in_if;
	logic valid;
	logic ready;
	logic [7:0] i_byte;
	logic [7:0] q_byte;

	modport source(output valid, output i_byte, output q_byte, input ready);
	modport sink(input valid, input i_byte, input q_byte, output ready);
endinterface

// ----- src/ddc_out_if.sv -----
interface ddc_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] out_i;
	logic signed [15:0] out_q;

	modport source(output valid, output out_i, output out_q, input ready);
	modport sink(input valid, input out_i, input out_q, output ready);
endinterface

// ----- src/ddc_ctrl.sv -----
module ddc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ddc_pkg::status_t sts,
	output ddc_pkg::cmd_t   cmd
);
	import ddc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_CORDIC;
				end
			end
			S_CORDIC: begin
				cmd.cordic = 1'b1;
				if (sts.cordic_last) state_d = S_MIX_I;
			end
			S_MIX_I: begin
				cmd.mix_i = 1'b1;
				state_d = S_MIX_Q;
			end
			S_MIX_Q: begin
				cmd.mix_q = 1'b1;
				state_d = S_WRITE;
			end
			S_WRITE: begin
				cmd.write = 1'b1;
				state_d = sts.fire ? S_FIR_START : S_IDLE;
			end
			S_FIR_START: begin
				cmd.fir_start = 1'b1;
				state_d = S_FIR;
			end
			S_FIR: begin
				if (!sts.fir_busy) state_d = S_OUT;
			end
			S_OUT: begin
				if (!sts.out_full) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// ----- src/ddc_datapath.sv -----
module ddc_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  ddc_pkg::cmd_t    cmd,
	output ddc_pkg::status_t sts,
	input  logic [7:0]       i_byte,
	input  logic [7:0]       q_byte,
	input  logic             wr_en,
	input  logic [0:0]       wr_index,
	input  logic [31:0]      wr_data,
	ddc_out_if.source        out_ch
);
	import ddc_pkg::*;

	logic [31:0] phase_step_q;
	logic [7:0] decimation_q;
	logic [31:0] nco_phase_q;
	logic [7:0] count_q;
	logic [ADDR_BITS-1:0] wp_q;
	logic [ADDR_BITS-1:0] newest_q;
	logic [ADDR_BITS:0] fill_q;

	logic signed [SAMPLE_BITS-1:0] si_q;
	logic signed [SAMPLE_BITS-1:0] sq_q;
	logic flip_q;
	logic signed [CW-1:0] x_q;
	logic signed [CW-1:0] y_q;
	logic signed [CW-1:0] z_q;
	logic [ITER_BITS-1:0] iter_q;

	logic signed [MIX_BITS-1:0] pa_q;
	logic signed [MIX_BITS-1:0] pb_q;
	logic signed [SAMPLE_BITS-1:0] mix_i_q;

	logic [31:0] mem [TAPS];
	logic issue_q;
	logic [ADDR_BITS-1:0] rd_idx_q;
	logic [ADDR_BITS:0] k_q;
	logic v_s1;
	logic zero_s1;
	logic [31:0] rdata_s1;
	logic signed [COEF_BITS-1:0] tap_s1;
	logic v_s2;
	logic signed [COEF_BITS+SAMPLE_BITS-1:0] prod_i_s2;
	logic signed [COEF_BITS+SAMPLE_BITS-1:0] prod_q_s2;
	logic signed [ACC_BITS-1:0] acc_i_q;
	logic signed [ACC_BITS-1:0] acc_q_q;

	logic out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_i_q;
	logic signed [SAMPLE_BITS-1:0] out_q_q;

	logic [31:0] p_flip;
	logic signed [CW-1:0] c_val;
	logic signed [CW-1:0] s_val;
	logic [7:0] count_next;

	function automatic logic signed [SAMPLE_BITS-1:0] mix_round(
		logic signed [MIX_BITS:0] v);
		logic signed [MIX_BITS:0] r;
		logic signed [MIX_BITS:0] hi;
		logic signed [MIX_BITS:0] lo;
		hi = (MIX_BITS+1)'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
		lo = -hi - 1;
		r = (v + (MIX_BITS+1)'(longint'(1) <<< 29)) >>> 30;
		if (r > hi) return SAMPLE_BITS'(hi);
		if (r < lo) return SAMPLE_BITS'(lo);
		return SAMPLE_BITS'(r);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] fir_round(
		logic signed [ACC_BITS-1:0] v);
		logic signed [ACC_BITS-1:0] r;
		logic signed [ACC_BITS-1:0] hi;
		logic signed [ACC_BITS-1:0] lo;
		hi = ACC_BITS'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
		lo = -hi - 1;
		r = (v + ACC_BITS'(longint'(1) <<< (COEF_BITS - 2))) >>> (COEF_BITS - 1);
		if (r > hi) return SAMPLE_BITS'(hi);
		if (r < lo) return SAMPLE_BITS'(lo);
		return SAMPLE_BITS'(r);
	endfunction

	assign p_flip = ((nco_phase_q[31:30] == 2'd1) || (nco_phase_q[31:30] == 2'd2))
		? (nco_phase_q ^ 32'h80000000) : nco_phase_q;
	assign c_val = flip_q ? -x_q : x_q;
	assign s_val = flip_q ? -y_q : y_q;
	assign count_next = count_q + 8'd1;

	assign sts.cordic_last = (iter_q == ITER_BITS'(ITERS - 1));
	assign sts.fire = (count_next == decimation_q);
	assign sts.fir_busy = issue_q | v_s1 | v_s2;
	assign sts.out_full = out_valid_q;

	assign out_ch.valid = out_valid_q;
	assign out_ch.out_i = out_i_q;
	assign out_ch.out_q = out_q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= PHASE_STEP_RESET;
			decimation_q <= DECIMATION_RESET;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_PHASE_STEP: phase_step_q <= wr_data;
				REG_DECIMATION: decimation_q <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nco_phase_q <= '0;
			count_q <= '0;
			wp_q <= '0;
			fill_q <= '0;
		end else begin
			if (cmd.load) nco_phase_q <= nco_phase_q + phase_step_q;
			if (cmd.write) begin
				count_q <= sts.fire ? 8'd0 : count_next;
				wp_q <= (wp_q == ADDR_BITS'(TAPS - 1)) ? '0 : wp_q + 1'b1;
				if (fill_q != (ADDR_BITS+1)'(TAPS)) fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			si_q <= SAMPLE_ROM[i_byte];
			sq_q <= SAMPLE_ROM[q_byte];
			flip_q <= (nco_phase_q[31:30] == 2'd1) || (nco_phase_q[31:30] == 2'd2);
			x_q <= CW'(CORDIC_GAIN_INV);
			y_q <= '0;
			z_q <= CW'($signed(p_flip));
			iter_q <= '0;
		end else if (cmd.cordic) begin
			if (!z_q[CW-1]) begin
				x_q <= x_q - (y_q >>> iter_q);
				y_q <= y_q + (x_q >>> iter_q);
				z_q <= z_q - ATAN_ROM[iter_q];
			end else begin
				x_q <= x_q + (y_q >>> iter_q);
				y_q <= y_q - (x_q >>> iter_q);
				z_q <= z_q + ATAN_ROM[iter_q];
			end
			iter_q <= iter_q + 1'b1;
		end
		if (cmd.mix_i) begin
			pa_q <= MIX_BITS'(si_q * c_val);
			pb_q <= MIX_BITS'(sq_q * s_val);
		end
		if (cmd.mix_q) begin
			mix_i_q <= mix_round((MIX_BITS+1)'(pa_q) + (MIX_BITS+1)'(pb_q));
			pa_q <= MIX_BITS'(sq_q * c_val);
			pb_q <= MIX_BITS'(si_q * s_val);
		end
		if (cmd.write) begin
			mem[wp_q] <= {mix_i_q, mix_round((MIX_BITS+1)'(pa_q) - (MIX_BITS+1)'(pb_q))};
			newest_q <= wp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fir_start) begin
				issue_q <= 1'b1;
			end else if (issue_q && (k_q == (ADDR_BITS+1)'(TAPS - 1))) begin
				issue_q <= 1'b0;
			end
			v_s1 <= issue_q;
			v_s2 <= v_s1;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fir_start) begin
			rd_idx_q <= newest_q;
			k_q <= '0;
			acc_i_q <= '0;
			acc_q_q <= '0;
		end else begin
			if (issue_q) begin
				rd_idx_q <= (rd_idx_q == '0) ? ADDR_BITS'(TAPS - 1) : rd_idx_q - 1'b1;
				k_q <= k_q + 1'b1;
			end
			if (v_s2) begin
				acc_i_q <= acc_i_q + ACC_BITS'(prod_i_s2);
				acc_q_q <= acc_q_q + ACC_BITS'(prod_q_s2);
			end
		end
		rdata_s1 <= mem[rd_idx_q];
		tap_s1 <= TAP_ROM[k_q[ADDR_BITS-1:0]];
		zero_s1 <= (k_q >= fill_q);
		if (zero_s1) begin
			prod_i_s2 <= '0;
			prod_q_s2 <= '0;
		end else begin
			prod_i_s2 <= tap_s1 * $signed(rdata_s1[31:16]);
			prod_q_s2 <= tap_s1 * $signed(rdata_s1[15:0]);
		end
		if (cmd.out_load) begin
			out_i_q <= fir_round(acc_i_q);
			out_q_q <= fir_round(acc_q_q);
		end
	end
endmodule

// ----- src/nco_mix_decimating_fir_top.sv -----
// Each input item runs the CORDIC, both mix steps and the delay-line write; an
// item that completes a decimation group then runs the FIR pass and loads the
// result before the next transfer is taken. Each item needs 30 CORDIC iterations,
// plus one MAC pass over all 401 taps through the single delay-line read port when
// a result is due. Reset clears NCO phase, write pointer, fill and decimation
// counts; the delay line reads zero until written. Registers return to defaults.
module nco_mix_decimating_fir_top (
	input  logic        clk,
	input  logic        arst_n,
	ddc_in_if.sink      in_ch,
	ddc_out_if.source   out_ch,
	input  logic        wr_en,
	input  logic [0:0]  wr_index,
	input  logic [31:0] wr_data
);
	import ddc_pkg::*;

	cmd_t cmd;
	status_t sts;

	ddc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ddc_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.i_byte   (in_ch.i_byte),
		.q_byte   (in_ch.q_byte),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.out_ch   (out_ch)
	);
endmodule

// ----- test/ddc_tb_if.sv -----
`timescale 1ns / 1ps
// The block's own channel interfaces live with the RTL; nothing extra is needed here.
package ddc_tb_pkg;
	import ddc_pkg::*;

	typedef struct {
		logic signed [15:0] out_i;
		logic signed [15:0] out_q;
	} ddc_result_t;
endpackage

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import ddc_pkg::*;
	import ddc_tb_pkg::*;

	class ddc_scoreboard;
		logic [31:0] step_reg;
		logic [7:0] decim_reg;
		logic [31:0] phase;
		longint line_i [TAPS];
		longint line_q [TAPS];
		longint tap_w [TAPS];
		int wpos;
		logic [7:0] count;
		ddc_result_t pending [$];
		int errors;
		int results;

		function new();
			longint raw [TAPS];
			longint sum;
			longint d;
			longint ad;
			longint r;
			longint acc;
			longint pl;
			longint c1;
			longint c2;
			longint c3;
			longint s;
			longint dummy;
			step_reg = PHASE_STEP_RESET;
			decim_reg = DECIMATION_RESET;
			phase = 0;
			wpos = 0;
			count = 0;
			errors = 0;
			results = 0;
			sum = 0;
			for (int i = 0; i < TAPS; i++) begin
				line_i[i] = 0;
				line_q[i] = 0;
				d = 2 * longint'(i) - (TAPS - 1);
				ad = (d < 0) ? -d : d;
				if (d == 0) begin
					r = (64'sd26986075409 * CUTOFF_HZ) / DEVICE_RATE_HZ;
				end else begin
					pl = ((longint'(CUTOFF_HZ) * ad) <<< 31) / DEVICE_RATE_HZ;
					rotate(pl[31:0], dummy, s);
					r = (s * 8) / ad;
				end
				pl = (longint'(i) <<< 32) / (TAPS - 1);
				rotate(pl[31:0], c1, s);
				pl = (longint'(2 * i) <<< 32) / (TAPS - 1);
				rotate(pl[31:0], c2, s);
				pl = (longint'(3 * i) <<< 32) / (TAPS - 1);
				rotate(pl[31:0], c3, s);
				acc = 376177 * 64'sd1073741824 - 512009 * c1 + 148143 * c2 - 12247 * c3;
				raw[i] = (r * (acc >>> 30)) >>> 20;
				sum += raw[i];
			end
			for (int i = 0; i < TAPS; i++)
				tap_w[i] = (sum == 0) ? 0 : sat(rdiv(raw[i] * (longint'(1) <<< (COEF_BITS - 1)),
					sum), COEF_BITS);
		endfunction

		static function longint sat(longint v, int bits);
			longint hi;
			hi = (longint'(1) <<< (bits - 1)) - 1;
			if (v > hi) return hi;
			if (v < -hi - 1) return -hi - 1;
			return v;
		endfunction

		static function longint rdiv(longint n, longint d);
			longint an;
			longint ad;
			longint q;
			an = (n < 0) ? -n : n;
			ad = (d < 0) ? -d : d;
			q = (2 * an + ad) / (2 * ad);
			return ((n < 0) != (d < 0)) ? -q : q;
		endfunction

		static function void rotate(logic [31:0] ph, output longint c, output longint s);
			logic flip;
			logic [31:0] p;
			longint x;
			longint y;
			longint z;
			longint dx;
			longint dy;
			longint at;
			flip = (ph[31:30] == 2'd1) || (ph[31:30] == 2'd2);
			p = flip ? (ph ^ 32'h80000000) : ph;
			z = p[31] ? (longint'(p) - 64'sd4294967296) : longint'(p);
			x = 652032874;
			y = 0;
			for (int i = 0; i < 30; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				at = ATAN_TAB[i];
				if (z >= 0) begin
					x -= dx; y += dy; z -= at;
				end else begin
					x += dx; y -= dy; z += at;
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		static function longint to_sample(logic [7:0] b);
			return sat(rdiv((2 * longint'(b) - 255) * 32768, 255), SAMPLE_BITS);
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] v);
			if (idx == REG_PHASE_STEP) step_reg = v;
			else decim_reg = v[7:0];
		endfunction

		function void note_sample(logic [7:0] ib, logic [7:0] qb);
			longint si;
			longint sq;
			longint c;
			longint s;
			longint ai;
			longint aq;
			int idx;
			ddc_result_t res;
			si = to_sample(ib);
			sq = to_sample(qb);
			rotate(phase, c, s);
			phase = phase + step_reg;
			line_i[wpos] = sat((si * c + sq * s + (64'sd1 <<< 29)) >>> 30, SAMPLE_BITS);
			line_q[wpos] = sat((sq * c - si * s + (64'sd1 <<< 29)) >>> 30, SAMPLE_BITS);
			idx = wpos;
			wpos = (wpos + 1) % TAPS;
			count = count + 8'd1;
			if (count != decim_reg) return;
			count = 0;
			ai = 0;
			aq = 0;
			for (int k = 0; k < TAPS; k++) begin
				ai += tap_w[k] * line_i[idx];
				aq += tap_w[k] * line_q[idx];
				idx = (idx == 0) ? TAPS - 1 : idx - 1;
			end
			res.out_i = 16'(sat((ai + (64'sd1 <<< 16)) >>> 17, SAMPLE_BITS));
			res.out_q = 16'(sat((aq + (64'sd1 <<< 16)) >>> 17, SAMPLE_BITS));
			pending = {pending, res};
		endfunction

		function void check_output(logic signed [15:0] oi, logic signed [15:0] oq);
			ddc_result_t e;
			results++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected output i=%0d q=%0d", $time, oi, oq);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (oi !== e.out_i) begin
				$display("%0t: out_i expected %0d actual %0d", $time, e.out_i, oi);
				errors++;
			end
			if (oq !== e.out_q) begin
				$display("%0t: out_q expected %0d actual %0d", $time, e.out_q, oq);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic wr_en = 0;
	logic [0:0] wr_index = 0;
	logic [31:0] wr_data = 0;
	ddc_in_if in_ch();
	ddc_out_if out_ch();
	ddc_scoreboard downconv;
	int sent;

	initial begin
		in_ch.valid = 0;
		in_ch.i_byte = 0;
		in_ch.q_byte = 0;
		out_ch.ready = 0;
	end

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	nco_mix_decimating_fir_top dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= v;
		@(posedge clk);
		wr_en <= 0;
		downconv.write_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic send(logic [7:0] ib, logic [7:0] qb);
		int gap;
		gap = $urandom_range(0, 6);
		if (gap != 0) begin
			in_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.i_byte <= ib;
		in_ch.q_byte <= qb;
		do @(posedge clk); while (!in_ch.ready);
		downconv.note_sample(ib, qb);
		sent++;
	endtask

	// drain and wait out any item still in flight
	task automatic settle();
		in_ch.valid <= 0;
		while (downconv.pending.size() != 0) @(posedge clk);
		repeat (500) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready)
			downconv.check_output(out_ch.out_i, out_ch.out_q);
	end

	initial begin : drain
		int wait_cycles;
		forever begin
			wait_cycles = $urandom_range(0, 6);
			if (wait_cycles != 0) begin
				out_ch.ready <= 0;
				repeat (wait_cycles) @(posedge clk);
			end
			out_ch.ready <= 1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	initial begin
		downconv = new();
		sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes and every byte bit, default settings
		send(8'd0, 8'd0);
		send(8'd255, 8'd255);
		send(8'd0, 8'd255);
		send(8'd255, 8'd0);
		send(8'd127, 8'd128);
		for (int b = 0; b < 8; b++) send(8'(1 << b), 8'(~(1 << b)));
		for (int n = 0; n < 7; n++) send(8'd255, 8'd0);
		settle();
		write_reg(REG_DECIMATION, 8'd1);
		write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
		for (int n = 0; n < 5; n++) send(8'd255, 8'd255);
		settle();
		write_reg(REG_PHASE_STEP, 32'd0);
		write_reg(REG_DECIMATION, 8'd30);
		for (int n = 0; n < 10; n++) send(8'($urandom), 8'($urandom));
		settle();
		// decimation lowered below the running count, down to zero
		write_reg(REG_DECIMATION, 8'd0);
		for (int n = 0; n < 250; n++) send(8'($urandom), 8'($urandom));
		settle();
		for (int ph = 0; ph < 3; ph++) begin
			write_reg(REG_PHASE_STEP, $urandom);
			write_reg(REG_DECIMATION, 8'($urandom_range(1, 12)));
			for (int n = 0; n < 40; n++)
				send(8'($urandom), 8'($urandom));
			settle();
		end
		$display("Sent %0d samples, checked %0d outputs over several step and decimation settings",
			sent, downconv.results);
		if (downconv.errors == 0 && downconv.pending.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end
endmodule
